[hw/rtl/tts_pkg.sv]
// Shared types, constants and state encodings for the triangle tangent-space block.
// Depends on nothing; every other file in hw/rtl imports it.
package tts_pkg;

    // Vertex coordinate width (signed Q16.16) and output unit format (Q1.14).
    localparam int COORD_WIDTH    = 32;
    localparam int UNIT_FRAC_BITS = 14;
    localparam int UNIT_W         = 16;

    // Derived datapath widths.
    localparam int DIFF_W    = COORD_WIDTH + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int WIDE_W    = PROD_W + 1;
    localparam int NORM_BITS = 30;
    localparam int SUM_W     = 2 * NORM_BITS + 4;
    localparam int LEN_W     = NORM_BITS + 2;
    localparam int NUM_W     = NORM_BITS + UNIT_FRAC_BITS + 1;
    localparam int CNT_W     = $clog2(NUM_W + 1);

    // Product sequence: fourteen for the determinant and raw vectors,
    // six more for the cross product.
    localparam int STEP_W        = 5;
    localparam int STEP_RAW_LAST = 13;
    localparam int STEP_CROSS    = 14;
    localparam int STEP_LAST     = 19;
    localparam int PAIRS         = 10;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [WIDE_W-1:0]      wide_t;
    typedef logic signed [UNIT_W-1:0]      unit_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_NGO,
        S_NWAIT,
        S_OUT
    } top_state_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SQ,
        N_ROOT,
        N_DLOAD,
        N_DIV,
        N_DONE
    } norm_state_t;

    typedef enum logic [1:0] {
        VSEL_TAN,
        VSEL_BIN,
        VSEL_NRM
    } vsel_t;

    typedef struct packed {
        logic start;
    } norm_ctrl_t;

    typedef struct packed {
        logic done;
        logic zero;
    } norm_stat_t;

endpackage

[hw/rtl/tts_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on tts_pkg for operand and product widths.
module tts_mul
    import tts_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  diff_t op_a,
    input  diff_t op_b,
    output prod_t prod
);

    prod_t prod_reg;

    // One product per enabled cycle, held until the next.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= op_a * op_b;
        end
    end

    assign prod = prod_reg;

endmodule

[hw/rtl/tts_norm.sv]
// Iterative vector normaliser: magnitude scaling, sum of squares, bitwise square
// root and restoring division, one step per cycle. Depends on tts_pkg.
module tts_norm
    import tts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  norm_ctrl_t ctrl,
    input  wide_t      vec_in [3],
    output norm_stat_t stat,
    output unit_t      unit_out [3]
);

    localparam logic [NUM_W-1:0] ONE_Q = NUM_W'(1) << UNIT_FRAC_BITS;

    norm_state_t state_reg, state_next;

    logic [WIDE_W-1:0] mag_reg [3];
    logic              neg_reg [3];
    logic [1:0]        idx_reg;
    logic [SUM_W-1:0]  acc_reg;
    logic [SUM_W-1:0]  x_reg;
    logic [SUM_W-1:0]  r_reg;
    logic [SUM_W-1:0]  bit_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              zero_reg;
    unit_t             out_reg [3];

    logic                   big;
    logic                   allz;
    logic [NORM_BITS-1:0]   s_sel;
    logic [2*NORM_BITS-1:0] sq;
    logic [SUM_W-1:0]       acc_sum;
    logic [SUM_W-1:0]       trial;
    logic                   root_ge;
    logic [LEN_W:0]         rem_sh;
    logic [LEN_W:0]         rem_sub;
    logic                   div_ge;
    logic [NUM_W-1:0]       q_fin;
    logic [NUM_W-1:0]       q_clamp;
    unit_t                  q_unit;

    // Step arithmetic shared by every state.
    always_comb
    begin
        big     = (|mag_reg[0][WIDE_W-1:NORM_BITS]) | (|mag_reg[1][WIDE_W-1:NORM_BITS])
                | (|mag_reg[2][WIDE_W-1:NORM_BITS]);
        allz    = (mag_reg[0] == '0) && (mag_reg[1] == '0) && (mag_reg[2] == '0);
        s_sel   = mag_reg[idx_reg][NORM_BITS-1:0];
        sq      = s_sel * s_sel;
        acc_sum = acc_reg + SUM_W'(sq);
        trial   = r_reg + bit_reg;
        root_ge = x_reg >= trial;
        rem_sh  = {rem_reg, num_reg[NUM_W-1]};
        div_ge  = rem_sh >= {1'b0, r_reg[LEN_W-1:0]};
        rem_sub = rem_sh - {1'b0, r_reg[LEN_W-1:0]};
        q_fin   = {num_reg[NUM_W-2:0], div_ge};
        q_clamp = (q_fin > ONE_Q) ? ONE_Q : q_fin;
        q_unit  = neg_reg[idx_reg] ? -unit_t'(q_clamp[UNIT_W-1:0])
                                   : unit_t'(q_clamp[UNIT_W-1:0]);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            N_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = N_SHIFT;
                end
            end
            N_SHIFT:
            begin
                if (!big)
                begin
                    state_next = allz ? N_DONE : N_SQ;
                end
            end
            N_SQ:
            begin
                if (idx_reg == 2'd2)
                begin
                    state_next = N_ROOT;
                end
            end
            N_ROOT:
            begin
                if (bit_reg[0])
                begin
                    state_next = N_DLOAD;
                end
            end
            N_DLOAD:
            begin
                state_next = N_DIV;
            end
            N_DIV:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = (idx_reg == 2'd2) ? N_DONE : N_DLOAD;
                end
            end
            N_DONE:
            begin
                state_next = N_IDLE;
            end
            default:
            begin
                state_next = N_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        stat.done = (state_reg == N_DONE);
        stat.zero = zero_reg;
        for (int i = 0; i < 3; i++)
        begin
            unit_out[i] = out_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            N_IDLE:
            begin
                if (ctrl.start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        neg_reg[i] <= vec_in[i][WIDE_W-1];
                        mag_reg[i] <= vec_in[i][WIDE_W-1] ? -vec_in[i] : vec_in[i];
                        out_reg[i] <= '0;
                    end
                    zero_reg <= 1'b0;
                end
            end
            N_SHIFT:
            begin
                if (big)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                end
                else if (allz)
                begin
                    zero_reg <= 1'b1;
                end
                else
                begin
                    acc_reg <= '0;
                    idx_reg <= 2'd0;
                end
            end
            N_SQ:
            begin
                acc_reg <= acc_sum;
                if (idx_reg == 2'd2)
                begin
                    x_reg   <= acc_sum;
                    r_reg   <= '0;
                    bit_reg <= SUM_W'(1) << (SUM_W - 2);
                    idx_reg <= 2'd0;
                end
                else
                begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
            N_ROOT:
            begin
                if (root_ge)
                begin
                    x_reg <= x_reg - trial;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            N_DLOAD:
            begin
                num_reg <= (NUM_W'(s_sel) << UNIT_FRAC_BITS) + NUM_W'(r_reg[LEN_W-1:1]);
                rem_reg <= '0;
                cnt_reg <= CNT_W'(NUM_W);
            end
            N_DIV:
            begin
                rem_reg <= div_ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
                num_reg <= q_fin;
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    out_reg[idx_reg] <= q_unit;
                    idx_reg          <= idx_reg + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

[hw/rtl/triangle_tangent_space_top.sv]
// Top level of the triangle tangent-space block: vertex store, product sequencer
// and output word. Depends on tts_pkg, tts_mul and tts_norm.
//
//  Channel  Valid      Stall      Word
//  in       in_valid   in_stall   pos_x/y/z, tex_u/v, model_end
//  out      out_valid  out_stall  tangent_*, binormal_*, normal_*, degenerate, last_of_triangle
//
// The first two vertices of a triangle are stored. The third starts 20 products
// on the shared multiplier and three passes of the normaliser, each pass a
// scaling shift, a 32-step square root and three 45-step divisions; the root
// and divisions are skipped when a vector is zero. Three output words follow, one
// per accepted cycle; input is stalled throughout.
// Reset clears the sequencers and vertex count; held vertices are not cleared.
module triangle_tangent_space_top
    import tts_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_stall,
    input  coord_t pos_x,
    input  coord_t pos_y,
    input  coord_t pos_z,
    input  coord_t tex_u,
    input  coord_t tex_v,
    input  logic   model_end,
    output logic   out_valid,
    input  logic   out_stall,
    output unit_t  tangent_x,
    output unit_t  tangent_y,
    output unit_t  tangent_z,
    output unit_t  binormal_x,
    output unit_t  binormal_y,
    output unit_t  binormal_z,
    output unit_t  normal_x,
    output unit_t  normal_y,
    output unit_t  normal_z,
    output logic   degenerate,
    output logic   last_of_triangle
);

    // Component slots of a stored vertex.
    localparam int CX = 0;
    localparam int CY = 1;
    localparam int CZ = 2;
    localparam int CU = 3;
    localparam int CV = 4;

    // Slots of the product pairs.
    localparam int P_DET = 0;
    localparam int P_TC  = 1;
    localparam int P_BC  = 4;
    localparam int P_NC  = 7;

    top_state_t state_reg, state_next;

    coord_t           held_reg [2][5];
    coord_t           cur_reg [5];
    logic [1:0]       slot_reg;
    logic [STEP_W-1:0] step_reg;
    logic             phase_reg;
    vsel_t            vsel_reg;
    logic             bad_reg;
    wide_t            pend_reg;
    wide_t            pair_reg [PAIRS];
    unit_t            t_reg [3];
    unit_t            b_reg [3];
    unit_t            o_reg [9];
    logic             deg_reg;
    logic [1:0]       cnt_reg;

    diff_t      d1 [5];
    diff_t      d2 [5];
    diff_t      op_a;
    diff_t      op_b;
    prod_t      prod;
    logic       mul_en;
    norm_ctrl_t nctrl;
    norm_stat_t nstat;
    wide_t      nvec [3];
    unit_t      nunit [3];
    logic       in_acc;
    logic       out_acc;
    logic       det_neg;
    logic       det_zero;
    logic       bad_fin;
    coord_t     vin [5];

    assign vin[CX] = pos_x;
    assign vin[CY] = pos_y;
    assign vin[CZ] = pos_z;
    assign vin[CU] = tex_u;
    assign vin[CV] = tex_v;

    // Edge and texture differences against the first vertex.
    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            d1[i] = DIFF_W'(held_reg[1][i]) - DIFF_W'(held_reg[0][i]);
            d2[i] = DIFF_W'(cur_reg[i]) - DIFF_W'(held_reg[0][i]);
        end
    end

    // Operand selection for each product step.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (step_reg)
            5'd0:  begin op_a = d1[CU]; op_b = d2[CV]; end
            5'd1:  begin op_a = d2[CU]; op_b = d1[CV]; end
            5'd2:  begin op_a = d2[CV]; op_b = d1[CX]; end
            5'd3:  begin op_a = d1[CV]; op_b = d2[CX]; end
            5'd4:  begin op_a = d2[CV]; op_b = d1[CY]; end
            5'd5:  begin op_a = d1[CV]; op_b = d2[CY]; end
            5'd6:  begin op_a = d2[CV]; op_b = d1[CZ]; end
            5'd7:  begin op_a = d1[CV]; op_b = d2[CZ]; end
            5'd8:  begin op_a = d1[CU]; op_b = d2[CX]; end
            5'd9:  begin op_a = d2[CU]; op_b = d1[CX]; end
            5'd10: begin op_a = d1[CU]; op_b = d2[CY]; end
            5'd11: begin op_a = d2[CU]; op_b = d1[CY]; end
            5'd12: begin op_a = d1[CU]; op_b = d2[CZ]; end
            5'd13: begin op_a = d2[CU]; op_b = d1[CZ]; end
            5'd14: begin op_a = DIFF_W'(t_reg[1]); op_b = DIFF_W'(b_reg[2]); end
            5'd15: begin op_a = DIFF_W'(t_reg[2]); op_b = DIFF_W'(b_reg[1]); end
            5'd16: begin op_a = DIFF_W'(t_reg[2]); op_b = DIFF_W'(b_reg[0]); end
            5'd17: begin op_a = DIFF_W'(t_reg[0]); op_b = DIFF_W'(b_reg[2]); end
            5'd18: begin op_a = DIFF_W'(t_reg[0]); op_b = DIFF_W'(b_reg[1]); end
            5'd19: begin op_a = DIFF_W'(t_reg[1]); op_b = DIFF_W'(b_reg[0]); end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    tts_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // Vector fed to the normaliser; the raw vectors take the sign of the determinant.
    always_comb
    begin
        det_neg  = pair_reg[P_DET][WIDE_W-1];
        det_zero = (pair_reg[P_DET] == '0);
        for (int i = 0; i < 3; i++)
        begin
            case (vsel_reg)
                VSEL_TAN: nvec[i] = det_neg ? -pair_reg[P_TC+i] : pair_reg[P_TC+i];
                VSEL_BIN: nvec[i] = det_neg ? -pair_reg[P_BC+i] : pair_reg[P_BC+i];
                VSEL_NRM: nvec[i] = pair_reg[P_NC+i];
                default:  nvec[i] = '0;
            endcase
        end
        bad_fin = bad_reg | nstat.zero | det_zero;
    end

    tts_norm u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (nctrl),
        .vec_in   (nvec),
        .stat     (nstat),
        .unit_out (nunit)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (slot_reg == 2'd2))
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (phase_reg && ((step_reg == STEP_W'(STEP_RAW_LAST))
                    || (step_reg == STEP_W'(STEP_LAST))))
                begin
                    state_next = S_NGO;
                end
            end
            S_NGO:
            begin
                state_next = S_NWAIT;
            end
            S_NWAIT:
            begin
                if (nstat.done)
                begin
                    case (vsel_reg)
                        VSEL_TAN: state_next = S_NGO;
                        VSEL_BIN: state_next = S_MUL;
                        default:  state_next = S_OUT;
                    endcase
                end
            end
            S_OUT:
            begin
                if (out_acc && (cnt_reg == 2'd2))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Handshake and unit control.
    always_comb
    begin
        in_stall    = (state_reg != S_IDLE);
        out_valid   = (state_reg == S_OUT);
        mul_en      = (state_reg == S_MUL) && !phase_reg;
        nctrl.start = (state_reg == S_NGO);
        in_acc      = in_valid && !in_stall;
        out_acc     = out_valid && !out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            slot_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
            begin
                slot_reg <= ((slot_reg == 2'd2) || model_end) ? 2'd0 : slot_reg + 2'd1;
            end
        end
    end

    // Vertex store, product sequencing and output word.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    for (int i = 0; i < 5; i++)
                    begin
                        if (slot_reg == 2'd2)
                        begin
                            cur_reg[i] <= vin[i];
                        end
                        else
                        begin
                            held_reg[slot_reg[0]][i] <= vin[i];
                        end
                    end
                    step_reg  <= '0;
                    phase_reg <= 1'b0;
                    bad_reg   <= 1'b0;
                    vsel_reg  <= VSEL_TAN;
                end
            end
            S_MUL:
            begin
                phase_reg <= !phase_reg;
                if (phase_reg)
                begin
                    if (!step_reg[0])
                    begin
                        pend_reg <= WIDE_W'(prod);
                    end
                    else
                    begin
                        pair_reg[step_reg[STEP_W-1:1]] <= pend_reg - WIDE_W'(prod);
                    end
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(STEP_LAST))
                    begin
                        vsel_reg <= VSEL_NRM;
                    end
                end
            end
            S_NWAIT:
            begin
                if (nstat.done)
                begin
                    bad_reg <= bad_reg | nstat.zero;
                    case (vsel_reg)
                        VSEL_TAN:
                        begin
                            t_reg    <= nunit;
                            vsel_reg <= VSEL_BIN;
                        end
                        VSEL_BIN:
                        begin
                            b_reg     <= nunit;
                            step_reg  <= STEP_W'(STEP_CROSS);
                            phase_reg <= 1'b0;
                        end
                        default:
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                o_reg[i]   <= bad_fin ? unit_t'(0) : t_reg[i];
                                o_reg[3+i] <= bad_fin ? unit_t'(0) : b_reg[i];
                                o_reg[6+i] <= bad_fin ? unit_t'(0) : nunit[i];
                            end
                            deg_reg <= bad_fin;
                            cnt_reg <= 2'd0;
                        end
                    endcase
                end
            end
            S_OUT:
            begin
                if (out_acc)
                begin
                    cnt_reg <= cnt_reg + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign tangent_x        = o_reg[0];
    assign tangent_y        = o_reg[1];
    assign tangent_z        = o_reg[2];
    assign binormal_x       = o_reg[3];
    assign binormal_y       = o_reg[4];
    assign binormal_z       = o_reg[5];
    assign normal_x         = o_reg[6];
    assign normal_y         = o_reg[7];
    assign normal_z         = o_reg[8];
    assign degenerate       = deg_reg;
    assign last_of_triangle = (cnt_reg == 2'd2);

endmodule

[tb/tb_triangle_tangent_space_top.sv]
// Self-checking testbench for triangle_tangent_space_top: a vertex driver, a
// result monitor and a bit-exact tangent-frame predictor. Depends on tts_pkg and the RTL.
module tb_triangle_tangent_space_top;
    import tts_pkg::*;

    typedef logic signed [127:0] wide128_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        coord_t u;
        coord_t v;
        logic   last_vertex;
    } vertex_t;

    typedef struct packed {
        logic [8:0][UNIT_W-1:0] vec;
        logic                   degen;
        logic                   last;
    } frame_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 400;
    localparam int LONG_HOLD = 2000;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   in_stall;
    coord_t pos_x = '0, pos_y = '0, pos_z = '0, tex_u = '0, tex_v = '0;
    logic   model_end = 1'b0;
    logic   out_valid;
    logic   out_stall = 1'b0;
    unit_t  tangent_x, tangent_y, tangent_z;
    unit_t  binormal_x, binormal_y, binormal_z;
    unit_t  normal_x, normal_y, normal_z;
    logic   degenerate, last_of_triangle;

    triangle_tangent_space_top u_top (.*);

    // Clock and a single reset at the start.
    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    vertex_t   vertex_q[$];
    frame_t    frame_q[$];
    vertex_t   held_vtx[2];
    int        slot = 0;
    int        failures = 0;
    int        cycles = 0;
    int        triangles = 0;
    int        degenerate_seen = 0;
    int        dropped = 0;
    int        results_seen = 0;
    string     field_name[9] = '{"tangent_x", "tangent_y", "tangent_z",
                                 "binormal_x", "binormal_y", "binormal_z",
                                 "normal_x", "normal_y", "normal_z"};

    // Integer square root, bit by bit.
    function automatic longint unsigned root64(input longint unsigned x);
        longint unsigned r, bit_w;
        r = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > x)
            bit_w >>= 2;
        while (bit_w != 0)
        begin
            if (x >= r + bit_w)
            begin
                x -= r + bit_w;
                r = (r >> 1) + bit_w;
            end
            else
                r >>= 1;
            bit_w >>= 2;
        end
        return r;
    endfunction

    // Scales a wide vector to at most 30 bits and divides by its length in Q1.14.
    function automatic bit unit_vector(input wide128_t c0, c1, c2,
                                       output int o0, o1, o2);
        wide128_t        c[3];
        logic [127:0]    mag[3];
        bit              neg[3];
        int              bits, k, o[3];
        longint unsigned s[3], sum, len, q;
        c[0] = c0; c[1] = c1; c[2] = c2;
        bits = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = c[i] < 0;
            mag[i] = neg[i] ? -c[i] : c[i];
            for (int j = 127; j >= 0; j--)
                if (mag[i][j])
                begin
                    if (j + 1 > bits)
                        bits = j + 1;
                    break;
                end
            o[i] = 0;
        end
        o0 = 0; o1 = 0; o2 = 0;
        if (bits == 0)
            return 1'b0;
        k = bits > NORM_BITS ? bits - NORM_BITS : 0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            s[i] = 64'(mag[i] >> k);
            sum += s[i] * s[i];
        end
        len = root64(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((s[i] << UNIT_FRAC_BITS) + len / 2) / len;
            if (q > (64'd1 << UNIT_FRAC_BITS))
                q = 64'd1 << UNIT_FRAC_BITS;
            o[i] = neg[i] ? -int'(q) : int'(q);
        end
        o0 = o[0]; o1 = o[1]; o2 = o[2];
        return 1'b1;
    endfunction

    // Tangent frame of one triangle from its three vertices.
    function automatic frame_t tangent_frame(input vertex_t a, b, c);
        wide128_t e1[3], e2[3], du1, dv1, du2, dv2, det, tc[3], bc[3];
        int       t[3], bn[3], n[3];
        bit       bad;
        frame_t   f;
        e1[0] = wide128_t'(b.x) - a.x; e1[1] = wide128_t'(b.y) - a.y;
        e1[2] = wide128_t'(b.z) - a.z;
        e2[0] = wide128_t'(c.x) - a.x; e2[1] = wide128_t'(c.y) - a.y;
        e2[2] = wide128_t'(c.z) - a.z;
        du1 = wide128_t'(b.u) - a.u; dv1 = wide128_t'(b.v) - a.v;
        du2 = wide128_t'(c.u) - a.u; dv2 = wide128_t'(c.v) - a.v;
        det = du1 * dv2 - du2 * dv1;
        bad = det == 0;
        for (int i = 0; i < 3; i++)
        begin
            tc[i] = dv2 * e1[i] - dv1 * e2[i];
            bc[i] = du1 * e2[i] - du2 * e1[i];
            if (det < 0)
            begin
                tc[i] = -tc[i];
                bc[i] = -bc[i];
            end
        end
        if (!unit_vector(tc[0], tc[1], tc[2], t[0], t[1], t[2]))
            bad = 1'b1;
        if (!unit_vector(bc[0], bc[1], bc[2], bn[0], bn[1], bn[2]))
            bad = 1'b1;
        if (!unit_vector(wide128_t'(t[1] * bn[2] - t[2] * bn[1]),
                         wide128_t'(t[2] * bn[0] - t[0] * bn[2]),
                         wide128_t'(t[0] * bn[1] - t[1] * bn[0]), n[0], n[1], n[2]))
            bad = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            f.vec[i]     = bad ? '0 : UNIT_W'(t[i]);
            f.vec[3 + i] = bad ? '0 : UNIT_W'(bn[i]);
            f.vec[6 + i] = bad ? '0 : UNIT_W'(n[i]);
        end
        f.degen = bad;
        f.last = 1'b0;
        return f;
    endfunction

    // Accepted vertex: hold it, or complete the triangle and queue three words.
    function automatic void accept_vertex(input vertex_t vt);
        frame_t f;
        if (slot < 2)
        begin
            held_vtx[slot] = vt;
            if (vt.last_vertex)
                dropped++;
            slot = vt.last_vertex ? 0 : slot + 1;
            return;
        end
        slot = 0;
        f = tangent_frame(held_vtx[0], held_vtx[1], vt);
        triangles++;
        if (f.degen)
            degenerate_seen++;
        for (int r = 0; r < 3; r++)
        begin
            f.last = r == 2;
            frame_q.push_back(f);
        end
    endfunction

    // Sender: bursts of words with random gaps, holding the word while stalled.
    vertex_t cur_vtx;
    int      burst_left = 0;
    int      gap_left = 0;

    always @(posedge clk)
    begin
        if (rst_n && !(in_valid && in_stall))
        begin
            if (in_valid)
                accept_vertex(cur_vtx);
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (vertex_q.size() != 0)
            begin
                cur_vtx = vertex_q.pop_front();
                pos_x <= cur_vtx.x; pos_y <= cur_vtx.y; pos_z <= cur_vtx.z;
                tex_u <= cur_vtx.u; tex_v <= cur_vtx.v;
                model_end <= cur_vtx.last_vertex;
                in_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: stall pattern changes mode now and then, with one long hold-off.
    int  mode = 0;
    int  mode_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && results_seen >= 30)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end
            else
                mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= $urandom_range(0, 9) < 3;
                    default: out_stall <= $urandom_range(0, 9) < 7;
                endcase
        end
    end

    // Result monitor: each accepted word against the oldest expectation.
    always @(posedge clk)
    begin
        frame_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            got.vec = {normal_z, normal_y, normal_x, binormal_z, binormal_y, binormal_x,
                       tangent_z, tangent_y, tangent_x};
            got.degen = degenerate;
            got.last = last_of_triangle;
            if (frame_q.size() == 0)
            begin
                $error("result word with no expectation waiting");
                failures++;
            end
            else
            begin
                want = frame_q.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got.vec[i] !== want.vec[i])
                    begin
                        $error("%s: expected %0d, got %0d", field_name[i],
                               $signed(want.vec[i]), $signed(got.vec[i]));
                        failures++;
                    end
                if (got.degen !== want.degen)
                begin
                    $error("degenerate: expected %0d, got %0d", want.degen, got.degen);
                    failures++;
                end
                if (got.last !== want.last)
                begin
                    $error("last_of_triangle: expected %0d, got %0d", want.last, got.last);
                    failures++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic void add_vertex(input coord_t x, y, z, u, v, input logic e);
        vertex_t vt;
        vt.x = x; vt.y = y; vt.z = z; vt.u = u; vt.v = v; vt.last_vertex = e;
        vertex_q.push_back(vt);
    endfunction

    // Random coordinate: full range, small values or near the maximum.
    function automatic coord_t rand_coord();
        case ($urandom_range(0, 3))
            0: return coord_t'($urandom);
            1: return coord_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            2: return coord_t'(int'($urandom_range(0, 8)) + 32'sh7fff_fff7);
            default: return coord_t'(int'($urandom_range(0, 1 << 18)) * 7);
        endcase
    endfunction

    function automatic void add_random_vertex(input logic e);
        add_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(), e);
    endfunction

    localparam coord_t ONE = 32'sh0001_0000;
    localparam coord_t MAXC = 32'sh7fff_ffff;
    localparam coord_t MINC = -32'sh8000_0000;

    initial
    begin
        int n_items;
        // Directed: plain triangle, mirrored UVs, zero determinant, zero tangent.
        add_vertex(0, 0, 0, 0, 0, 1'b0);
        add_vertex(ONE, 0, 0, ONE, 0, 1'b0);
        add_vertex(0, ONE, 0, 0, ONE, 1'b0);
        add_vertex(0, 0, 0, 0, 0, 1'b0);
        add_vertex(ONE, 0, 0, 0, ONE, 1'b0);
        add_vertex(0, ONE, 0, ONE, 0, 1'b0);
        add_vertex(0, 0, 0, 5, 5, 1'b0);
        add_vertex(ONE, 0, ONE, 5, 5, 1'b0);
        add_vertex(0, ONE, 0, 5, 5, 1'b0);
        add_vertex(ONE, ONE, ONE, 0, 0, 1'b0);
        add_vertex(ONE, ONE, ONE, ONE, 0, 1'b0);
        add_vertex(ONE, ONE, ONE, 0, ONE, 1'b0);
        // Extremes of every field.
        add_vertex(MINC, MINC, MINC, MINC, MINC, 1'b0);
        add_vertex(MAXC, MINC, MAXC, MAXC, MINC, 1'b0);
        add_vertex(MINC, MAXC, MAXC, MINC, MAXC, 1'b0);
        add_vertex(MAXC, MAXC, MAXC, MAXC, MAXC, 1'b0);
        add_vertex(-1, MINC, 0, MINC, MAXC, 1'b0);
        add_vertex(MINC, -1, MAXC, MAXC, -1, 1'b0);
        // Model end on the first, second and third vertex.
        add_vertex(ONE, 2, 3, 4, 5, 1'b1);
        add_vertex(7, ONE, 9, 10, 11, 1'b0);
        add_vertex(-7, 3, ONE, -ONE, 1, 1'b1);
        add_vertex(0, 0, 0, 0, 0, 1'b0);
        add_vertex(ONE, 3, 0, ONE, 9, 1'b0);
        add_vertex(4, ONE, 2, 3, ONE, 1'b1);

        // Random: mostly whole triangles, some cut short by a model end.
        n_items = 0;
        while (n_items < 156)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                if ($urandom_range(0, 1))
                begin
                    add_random_vertex(1'b1);
                    n_items++;
                end
                else
                begin
                    add_random_vertex(1'b0);
                    add_random_vertex(1'b1);
                    n_items += 2;
                end
            end
            else
            begin
                add_random_vertex(1'b0);
                add_random_vertex(1'b0);
                add_random_vertex($urandom_range(0, 7) == 0);
                n_items += 3;
            end
        end

        while (vertex_q.size() != 0 || in_valid)
            @(posedge clk);
        while (frame_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d triangles (%0d degenerate), %0d partial triangles dropped,",
                 triangles, degenerate_seen, dropped);
        $display("%0d result words checked in %0d cycles.", results_seen, cycles);
        if (failures == 0 && frame_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/tts_pkg.sv
hw/rtl/tts_mul.sv
hw/rtl/tts_norm.sv
hw/rtl/triangle_tangent_space_top.sv
tb/tb_triangle_tangent_space_top.sv
